FILE: src/loop_period_auto_tuner_core_defines.svh
// Assertion macros shared by the loop period auto-tuner RTL.
// Checks are compiled only when SYNTHESIS is not defined.
`ifndef LOOP_PERIOD_AUTO_TUNER_CORE_DEFINES_SVH
`define LOOP_PERIOD_AUTO_TUNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LPAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpat assertion failed");
// Next-cycle implication, disabled during reset.
`define LPAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpat assertion failed");
`else
`define LPAT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LPAT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/lpat_pkg.sv
// Types and constants of the loop period auto-tuner.
// No dependencies; used by every other file of the block but the assertion macros header.
`timescale 1ns / 1ps

package lpat_pkg;

   localparam int PERIOD_W   = 15;
   localparam int WARN_W     = 8;
   localparam int LOAD_W     = 16;
   localparam int SUM_W      = 24;
   localparam int CNT_W      = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0]    WINDOW_LEN       = 8'd200;
   localparam logic [CNT_W-1:0]    STARTUP_LOOPS    = 8'd200;
   localparam logic [LOAD_W-1:0]   FAIL_LIMIT_US    = 16'd20000;
   localparam logic [LOAD_W:0]     HEADROOM_US      = 17'd10;
   localparam logic [SUM_W-1:0]    SLACK_US         = 24'd5;
   localparam logic [SUM_W-1:0]    WINDOW_LEN_SUM   = SUM_W'(WINDOW_LEN);
   localparam logic [PERIOD_W-1:0] CAP_FLOOR_US     = 15'd500;
   localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = 15'd250;

   // Item kinds.
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_RESET = 1'b1;

   // Register index taken from the word address.
   localparam logic REG_MIN_PERIOD = 1'b0;

   typedef struct packed {
      logic                kind;
      logic [LOAD_W-1:0]   cpu_load_us;
      logic [LOAD_W-1:0]   loop_time_us;
   } item_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_us;
      logic [WARN_W-1:0]   warning_count;
      logic                overrun_fail;
      logic                filters_update;
   } result_type;

   // Configuration towards the tuning engine.
   typedef struct packed {
      logic                wr;
      logic [PERIOD_W-1:0] wdata;
      logic [PERIOD_W-1:0] min_period;
   } cfg_type;

endpackage

FILE: src/lpat_if.sv
// Channel and register-bus interfaces of the loop period auto-tuner.
// Depends on lpat_pkg.
`timescale 1ns / 1ps

interface lpat_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [lpat_pkg::LOAD_W-1:0]    cpu_load_us;
   logic [lpat_pkg::LOAD_W-1:0]    loop_time_us;

   modport source (output valid, kind, cpu_load_us, loop_time_us, input ready);
   modport sink   (input valid, kind, cpu_load_us, loop_time_us, output ready);
endinterface

interface lpat_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lpat_pkg::PERIOD_W-1:0]  period_us;
   logic [lpat_pkg::WARN_W-1:0]    warning_count;
   logic                           overrun_fail;
   logic                           filters_update;

   modport source (output valid, period_us, warning_count, overrun_fail, filters_update,
                   input ready);
   modport sink   (input valid, period_us, warning_count, overrun_fail, filters_update,
                   output ready);
endinterface

interface lpat_apb_if;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [lpat_pkg::CSR_ADDR_W-1:0] paddr;
   logic [lpat_pkg::CSR_DATA_W-1:0] pwdata;
   logic [lpat_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   modport source (output psel, penable, pwrite, paddr, pwdata, input prdata, pready);
   modport sink   (input psel, penable, pwrite, paddr, pwdata, output prdata, pready);
endinterface

FILE: src/loop_period_auto_tuner_core.sv
// Top level of the loop period auto-tuner: input register, engine and register file.
// Depends on lpat_pkg, lpat_if, lpat_csr and lpat_engine.
`timescale 1ns / 1ps

// Loop period auto-tuner. Each item on req_chan is either a loop tick carrying busy
// and loop time in microseconds or a reset request; every item yields exactly one
// result on rsp_chan with the current period, the warning count and the overrun and
// filter-update flags. An item is registered on acceptance and its result is then
// registered in the result register of the engine, where it is held until taken;
// a new item is taken in every cycle while rsp_chan keeps draining, and the update
// of the window state in the engine for each item sets that rate. The minimum
// period is written over csr_bus at byte address 0; a write also loads the period
// and clears the window, and is to be made only while no item is in flight.
module loop_period_auto_tuner_core (
   input  logic      clock,
   input  logic      reset,
   lpat_req_if.sink   req_chan,
   lpat_rsp_if.source rsp_chan,
   lpat_apb_if.sink   csr_bus
);

   lpat_pkg::cfg_type  cfg;
   lpat_pkg::item_type item_ff, item_in;
   logic               item_valid_ff, item_valid_in;
   logic               item_take;
   logic               req_fire;

   assign req_chan.ready = !item_valid_ff || item_take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign item_in.kind         = req_chan.kind;
   assign item_in.cpu_load_us  = req_chan.cpu_load_us;
   assign item_in.loop_time_us = req_chan.loop_time_us;

   always_comb begin
      if (req_fire) begin
         item_valid_in = 1'b1;
      end else if (item_take) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   lpat_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   lpat_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (item_ff),
      .item_valid (item_valid_ff),
      .item_take  (item_take),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: src/lpat_csr.sv
// Register file of the loop period auto-tuner: holds the minimum period.
// Depends on lpat_pkg and lpat_if.
`timescale 1ns / 1ps

module lpat_csr (
   input  logic              clock,
   input  logic              reset,
   lpat_apb_if.sink          csr_bus,
   output lpat_pkg::cfg_type cfg
);

   logic [lpat_pkg::PERIOD_W-1:0] min_period_ff;
   logic [lpat_pkg::PERIOD_W-1:0] min_period_in;
   logic                          wr_en;

   // Address bit 2 selects the register; only the first one exists.
   assign wr_en = csr_bus.psel && csr_bus.penable && csr_bus.pwrite
                  && (csr_bus.paddr[2] == lpat_pkg::REG_MIN_PERIOD);

   assign min_period_in = wr_en ? csr_bus.pwdata[lpat_pkg::PERIOD_W-1:0] : min_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= lpat_pkg::MIN_PERIOD_RESET;
      end else begin
         min_period_ff <= min_period_in;
      end
   end

   always_comb begin
      csr_bus.pready = 1'b1;
      if (csr_bus.paddr[2] == lpat_pkg::REG_MIN_PERIOD) begin
         csr_bus.prdata = {{(lpat_pkg::CSR_DATA_W-lpat_pkg::PERIOD_W){1'b0}}, min_period_ff};
      end else begin
         csr_bus.prdata = '0;
      end
   end

   assign cfg.wr         = wr_en;
   assign cfg.wdata      = csr_bus.pwdata[lpat_pkg::PERIOD_W-1:0];
   assign cfg.min_period = min_period_ff;

endmodule

FILE: src/lpat_engine.sv
// Tuning engine: window state, period decision and the result register.
// Depends on lpat_pkg, lpat_if and the assertion macros header.
`timescale 1ns / 1ps
`include "loop_period_auto_tuner_core_defines.svh"

module lpat_engine (
   input  logic               clock,
   input  logic               reset,
   input  lpat_pkg::cfg_type  cfg,
   input  lpat_pkg::item_type item,
   input  logic               item_valid,
   output logic               item_take,
   lpat_rsp_if.source         rsp_chan
);

   logic [lpat_pkg::CNT_W-1:0]    loops_ff,   loops_in;
   logic                          skip_ff,    skip_in;
   logic [lpat_pkg::SUM_W-1:0]    sum_ff,     sum_in;
   logic [lpat_pkg::CNT_W-1:0]    win_ff,     win_in;
   logic                          headroom_ff, headroom_in;
   logic [lpat_pkg::PERIOD_W-1:0] period_ff,  period_in;
   logic [lpat_pkg::WARN_W-1:0]   warn_ff,    warn_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   lpat_pkg::result_type          rsp_ff,     rsp_in;

   logic [lpat_pkg::CNT_W-1:0]    loops_inc;
   logic                          active;
   logic [lpat_pkg::PERIOD_W-1:0] faster;
   logic [lpat_pkg::PERIOD_W-1:0] cap;
   logic [lpat_pkg::PERIOD_W:0]   doubled;
   logic [lpat_pkg::SUM_W-1:0]    sum_add;
   logic [lpat_pkg::SUM_W-1:0]    limit;
   logic [lpat_pkg::CNT_W-1:0]    win_inc;
   logic                          tight;
   logic                          skip_clear;
   logic                          fail;
   logic                          update;

   // The result register frees up when it is empty or being drained.
   assign item_take = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      loops_inc = (loops_ff < lpat_pkg::STARTUP_LOOPS)
                  ? lpat_pkg::CNT_W'(loops_ff + 1'b1) : loops_ff;
      active    = (loops_inc >= lpat_pkg::STARTUP_LOOPS);
      faster    = ((period_ff >> 1) < cfg.min_period) ? cfg.min_period : (period_ff >> 1);
      cap       = (cfg.min_period > lpat_pkg::CAP_FLOOR_US) ? cfg.min_period
                                                            : lpat_pkg::CAP_FLOOR_US;
      doubled   = {period_ff, 1'b0};
      sum_add   = lpat_pkg::SUM_W'(sum_ff + {{(lpat_pkg::SUM_W-lpat_pkg::LOAD_W){1'b0}},
                                             item.cpu_load_us});
      // The average test is done on the sum against (period + 5) times the window length.
      limit     = lpat_pkg::SUM_W'(({{(lpat_pkg::SUM_W-lpat_pkg::PERIOD_W){1'b0}}, period_ff}
                                    + lpat_pkg::SLACK_US) * lpat_pkg::WINDOW_LEN_SUM);
      win_inc   = lpat_pkg::CNT_W'(win_ff + 1'b1);
      tight     = ({1'b0, item.cpu_load_us} + lpat_pkg::HEADROOM_US)
                  > {{(lpat_pkg::LOAD_W+1-lpat_pkg::PERIOD_W){1'b0}}, faster};
   end

   always_comb begin
      loops_in    = loops_ff;
      skip_in     = skip_ff;
      sum_in      = sum_ff;
      win_in      = win_ff;
      headroom_in = headroom_ff;
      period_in   = period_ff;
      warn_in     = warn_ff;
      skip_clear  = 1'b0;
      fail        = 1'b0;
      update      = 1'b0;
      if (cfg.wr) begin
         period_in   = cfg.wdata;
         sum_in      = '0;
         win_in      = '0;
         headroom_in = 1'b1;
      end else if (item_take) begin
         if (item.kind == lpat_pkg::KIND_RESET) begin
            skip_in     = 1'b1;
            sum_in      = '0;
            win_in      = '0;
            headroom_in = 1'b1;
         end else begin
            loops_in = loops_inc;
            if (active) begin
               if (skip_ff) begin
                  skip_in    = 1'b0;
                  skip_clear = 1'b1;
               end else begin
                  fail        = (item.loop_time_us > lpat_pkg::FAIL_LIMIT_US);
                  sum_in      = sum_add;
                  headroom_in = headroom_ff && !tight;
                  win_in      = win_inc;
                  if (win_inc >= lpat_pkg::WINDOW_LEN) begin
                     if (sum_add > limit) begin
                        period_in = (doubled < {1'b0, cap}) ? doubled[lpat_pkg::PERIOD_W-1:0]
                                                            : cap;
                        warn_in   = lpat_pkg::WARN_W'(warn_ff + 1'b1);
                     end else if (headroom_ff && !tight) begin
                        period_in = faster;
                     end
                     sum_in      = '0;
                     win_in      = '0;
                     headroom_in = 1'b1;
                     update      = (period_in != period_ff);
                  end
               end
            end
         end
      end
   end

   always_comb begin
      rsp_in.period_us      = period_in;
      rsp_in.warning_count  = warn_in;
      rsp_in.overrun_fail   = fail;
      rsp_in.filters_update = update;
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loops_ff     <= '0;
         skip_ff      <= 1'b0;
         sum_ff       <= '0;
         win_ff       <= '0;
         headroom_ff  <= 1'b1;
         period_ff    <= lpat_pkg::MIN_PERIOD_RESET;
         warn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         loops_ff     <= loops_in;
         skip_ff      <= skip_in;
         sum_ff       <= sum_in;
         win_ff       <= win_in;
         headroom_ff  <= headroom_in;
         period_ff    <= period_in;
         warn_ff      <= warn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.period_us      = rsp_ff.period_us;
   assign rsp_chan.warning_count  = rsp_ff.warning_count;
   assign rsp_chan.overrun_fail   = rsp_ff.overrun_fail;
   assign rsp_chan.filters_update = rsp_ff.filters_update;

   `LPAT_ASSERT_IMPL(a_win_range, clock, reset, 1'b1, win_ff < lpat_pkg::WINDOW_LEN)
   `LPAT_ASSERT_IMPL(a_empty_win_sum, clock, reset, win_ff == '0, sum_ff == '0)
   `LPAT_ASSERT_IMPL(a_period_floor, clock, reset, 1'b1, period_ff >= cfg.min_period)
   `LPAT_ASSERT_NEXT(a_skip_once, clock, reset, skip_clear, !skip_ff)

endmodule
